// ===== sv/frame_table_evict_select_unit_macros.svh =====
// Assertion macros for the frame table evict select unit.
// Each macro takes a label, the clock, the reset, and the two sides of the property.
`ifndef FRAME_TABLE_EVICT_SELECT_UNIT_MACROS_SVH
`define FRAME_TABLE_EVICT_SELECT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define FTES_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ftes assertion failed (same cycle)");

// Next-cycle implication
`define FTES_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ftes assertion failed (next cycle)");

`else

`define FTES_ASSERT_IMP(lbl, ck, rs, ante, cons)

`define FTES_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== sv/ftes_pkg.sv =====
`timescale 1ns / 1ps

package ftes_pkg;

  localparam int FRAMES   = 64;
  localparam int SLOT_W   = 6;
  localparam int PAGE_W   = 20;
  localparam int THREAD_W = 16;
  localparam int STAMP_W  = 32;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAMES - 1);

  typedef enum logic [2:0] {
    CMD_ALLOC       = 3'd0,
    CMD_FIND        = 3'd1,
    CMD_SET_PAGE    = 3'd2,
    CMD_MARK_DONE   = 3'd3,
    CMD_FREE        = 3'd4,
    CMD_CLEAR       = 3'd5,
    CMD_FREE_THREAD = 3'd6,
    CMD_EVICT       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NONE    = 2'd1,
    STAT_NO_PAGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_RESP
  } state_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [PAGE_W-1:0]   page;
    logic [THREAD_W-1:0] thread_id;
    logic                kernel_lookup;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   frame_slot;
    logic [PAGE_W-1:0]   unmap_page;
    logic [THREAD_W-1:0] unmap_thread;
  } rsp_t;

  // One slot's stored fields
  typedef struct packed {
    logic [THREAD_W-1:0] owner;
    logic [PAGE_W-1:0]   page;
    logic                page_set;
    logic                load_done;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // Slot memory write controls
  typedef struct packed {
    logic              all;
    logic              page;
    logic              done;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  // Candidate tracker controls
  typedef struct packed {
    logic              clear;
    logic              en_old;
    logic              en_new;
    logic [SLOT_W-1:0] idx;
  } pick_ctl_t;

  // Candidate tracker results
  typedef struct packed {
    logic              old_ok;
    logic [SLOT_W-1:0] old_idx;
    logic              new_ok;
    logic [SLOT_W-1:0] new_idx;
  } pick_res_t;

endpackage

// ===== sv/ftes_slot_mem.sv =====
`timescale 1ns / 1ps

module ftes_slot_mem (
  input  logic              clk,
  input  logic [ftes_pkg::SLOT_W-1:0] rd_addr,
  output ftes_pkg::entry_t  rd_data,
  input  ftes_pkg::mem_wr_t wr
);
  import ftes_pkg::*;

  logic [THREAD_W-1:0] owner_mem [FRAMES];
  logic [PAGE_W-1:0]   page_mem  [FRAMES];
  logic                pset_mem  [FRAMES];
  logic                done_mem  [FRAMES];
  logic [STAMP_W-1:0]  stamp_mem [FRAMES];

  // Write the selected fields, read one slot with registered data
  always_ff @(posedge clk) begin
    if (wr.all) begin
      owner_mem[wr.addr] <= wr.data.owner;
      page_mem[wr.addr]  <= wr.data.page;
      pset_mem[wr.addr]  <= wr.data.page_set;
      done_mem[wr.addr]  <= wr.data.load_done;
      stamp_mem[wr.addr] <= wr.data.stamp;
    end
    if (wr.page) begin
      page_mem[wr.addr] <= wr.data.page;
      pset_mem[wr.addr] <= 1'b1;
    end
    if (wr.done) begin
      done_mem[wr.addr] <= 1'b1;
    end
    rd_data.owner     <= owner_mem[rd_addr];
    rd_data.page      <= page_mem[rd_addr];
    rd_data.page_set  <= pset_mem[rd_addr];
    rd_data.load_done <= done_mem[rd_addr];
    rd_data.stamp     <= stamp_mem[rd_addr];
  end

endmodule

// ===== sv/ftes_pick_unit.sv =====
`timescale 1ns / 1ps

module ftes_pick_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  ftes_pkg::pick_ctl_t           ctl,
  input  logic [ftes_pkg::STAMP_W-1:0]  stamp,
  input  logic [ftes_pkg::STAMP_W-1:0]  next_stamp,
  output ftes_pkg::pick_res_t           res
);
  import ftes_pkg::*;

  logic [STAMP_W-1:0] age;
  logic [STAMP_W-1:0] old_age;
  logic [STAMP_W-1:0] new_age;
  logic               take_old;
  logic               take_new;

  // Age modulo 2^32, compared against the oldest and newest candidates
  always_comb begin
    age      = next_stamp - stamp;
    take_old = ctl.en_old && (!res.old_ok || (age > old_age));
    take_new = ctl.en_new && (!res.new_ok || (age < new_age));
  end

  // Track candidate presence, hold candidate index and age
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      res.old_ok <= 1'b0;
      res.new_ok <= 1'b0;
    end else begin
      if (take_old) res.old_ok <= 1'b1;
      if (take_new) res.new_ok <= 1'b1;
    end
    if (take_old) begin
      res.old_idx <= ctl.idx;
      old_age     <= age;
    end
    if (take_new) begin
      res.new_idx <= ctl.idx;
      new_age     <= age;
    end
  end

endmodule

// ===== sv/frame_table_evict_select_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload | Direction
// request  | req_valid, req_stall | req     | in
// response | rsp_valid, rsp_stall | rsp     | out
//
// Scan commands (alloc, find, free thread, evict select) walk the slot memory one
// slot per cycle through its single registered read port, stopping early for an alloc
// that finds a free slot. Single-slot commands act on the named slot alone.
// Reset clears the in-use bits and the age stamp counter; there is no clearing pass.
// A finished response sits in the output register until taken; the next request is
// accepted once the response is registered.
`include "frame_table_evict_select_unit_macros.svh"

module frame_table_evict_select_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ftes_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ftes_pkg::rsp_t  rsp
);
  import ftes_pkg::*;

  state_t              state;
  state_t              state_next;
  req_t                req_q;
  rsp_t                res;
  rsp_t                rsp_next;
  logic [SLOT_W-1:0]   idx;
  logic                iss_on;
  logic                ev_valid;
  logic [SLOT_W-1:0]   ev_idx;
  logic [FRAMES-1:0]   slot_used;
  logic [STAMP_W-1:0]  next_stamp;

  logic [SLOT_W-1:0]   rd_addr;
  entry_t              rd_data;
  mem_wr_t             wr;
  pick_ctl_t           pctl;
  pick_res_t           pres;

  logic req_fire;
  logic rsp_free;
  logic scan_cmd;
  logic scan_ev;
  logic scan_last;
  logic ev_used;
  logic own_hit;
  logic find_hit;
  logic alloc_hit;
  logic slot_ok;

  ftes_slot_mem u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  ftes_pick_unit u_pick (
    .clk        (clk),
    .rst        (rst),
    .ctl        (pctl),
    .stamp      (rd_data.stamp),
    .next_stamp (next_stamp),
    .res        (pres)
  );

  // Decode the slot under evaluation
  always_comb begin
    req_fire  = req_valid && !req_stall;
    rsp_free  = !rsp_valid || !rsp_stall;
    scan_cmd  = (req.cmd == CMD_ALLOC) || (req.cmd == CMD_FIND) ||
                (req.cmd == CMD_FREE_THREAD) || (req.cmd == CMD_EVICT);
    scan_ev   = (state == S_SCAN) && ev_valid;
    scan_last = scan_ev && (ev_idx == SLOT_LAST);
    ev_used   = slot_used[ev_idx];
    own_hit   = (rd_data.owner == req_q.thread_id);
    find_hit  = ev_used && own_hit &&
                (req_q.kernel_lookup ?
                 ({{(PAGE_W - SLOT_W){1'b0}}, ev_idx} == req_q.page) :
                 (rd_data.page_set && (rd_data.page == req_q.page)));
    alloc_hit = scan_ev && (req_q.cmd == CMD_ALLOC) && !ev_used;
    slot_ok   = (state == S_SLOT) && slot_used[req_q.slot];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_fire) state_next = scan_cmd ? S_SCAN : S_SLOT;
      S_SCAN: if (alloc_hit || scan_last) state_next = S_RESP;
      S_SLOT: state_next = S_RESP;
      S_RESP: if (rsp_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Drive handshake, memory and tracker controls
  always_comb begin
    req_stall = (state != S_IDLE);
    rd_addr   = (state == S_IDLE) ? req.slot : idx;

    wr                = '0;
    wr.addr           = req_q.slot;
    wr.data.owner     = req_q.thread_id;
    wr.data.page      = req_q.page;
    wr.data.page_set  = 1'b0;
    wr.data.load_done = 1'b0;
    wr.data.stamp     = next_stamp;
    if (alloc_hit) begin
      wr.all       = 1'b1;
      wr.addr      = ev_idx;
      wr.data.page = '0;
    end
    if (slot_ok && (req_q.cmd == CMD_SET_PAGE)) wr.page = 1'b1;
    if (slot_ok && (req_q.cmd == CMD_MARK_DONE)) wr.done = 1'b1;

    pctl.clear  = req_fire;
    pctl.idx    = ev_idx;
    pctl.en_old = scan_ev &&
                  (((req_q.cmd == CMD_FIND) && find_hit) ||
                   ((req_q.cmd == CMD_EVICT) && ev_used && rd_data.load_done && own_hit));
    pctl.en_new = scan_ev && (req_q.cmd == CMD_EVICT) && ev_used && rd_data.load_done;
  end

  // Assemble the response
  always_comb begin
    rsp_next = res;
    case (req_q.cmd)
      CMD_FIND: begin
        rsp_next = '{STAT_NONE, '0, '0, '0};
        if (pres.old_ok) rsp_next = '{STAT_OK, pres.old_idx, '0, '0};
      end
      CMD_EVICT: begin
        rsp_next = '{STAT_NONE, '0, '0, '0};
        if (pres.old_ok) rsp_next = '{STAT_OK, pres.old_idx, '0, '0};
        else if (pres.new_ok) rsp_next = '{STAT_OK, pres.new_idx, '0, '0};
      end
      default: rsp_next = res;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iss_on     <= 1'b0;
      ev_valid   <= 1'b0;
      slot_used  <= '0;
      next_stamp <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      ev_valid <= (state == S_SCAN) && iss_on;
      if (req_fire) begin
        iss_on <= 1'b1;
      end else if ((state == S_SCAN) && (idx == SLOT_LAST)) begin
        iss_on <= 1'b0;
      end
      if (alloc_hit) begin
        slot_used[ev_idx] <= 1'b1;
        next_stamp        <= next_stamp + STAMP_W'(1);
      end
      if (scan_ev && (req_q.cmd == CMD_FREE_THREAD) && ev_used && own_hit) begin
        slot_used[ev_idx] <= 1'b0;
      end
      if (slot_ok && ((req_q.cmd == CMD_FREE) ||
                      ((req_q.cmd == CMD_CLEAR) && rd_data.page_set))) begin
        slot_used[req_q.slot] <= 1'b0;
      end
      if ((state == S_RESP) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold request, scan index and payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q <= req;
      idx   <= '0;
      res   <= '{(req.cmd == CMD_FREE_THREAD) ? STAT_OK : STAT_NONE, '0, '0, '0};
    end else if ((state == S_SCAN) && iss_on) begin
      idx <= idx + 1'b1;
    end
    ev_idx <= idx;
    if (alloc_hit) begin
      res.status     <= STAT_OK;
      res.frame_slot <= ev_idx;
    end
    if (slot_ok) begin
      case (req_q.cmd) inside
        CMD_SET_PAGE, CMD_MARK_DONE, CMD_FREE: begin
          res.status     <= STAT_OK;
          res.frame_slot <= req_q.slot;
        end
        CMD_CLEAR: begin
          if (!rd_data.page_set) begin
            res.status <= STAT_NO_PAGE;
          end else begin
            res.status       <= STAT_OK;
            res.frame_slot   <= req_q.slot;
            res.unmap_page   <= rd_data.page;
            res.unmap_thread <= rd_data.owner;
          end
        end
        default: ;
      endcase
    end
    if ((state == S_RESP) && rsp_free) begin
      rsp <= rsp_next;
    end
  end

  `FTES_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)
  `FTES_ASSERT_NXT(a_alloc_marks_used, clk, rst, alloc_hit, slot_used[$past(ev_idx)])
  `FTES_ASSERT_NXT(a_stamp_step, clk, rst, alloc_hit, next_stamp == $past(next_stamp) + STAMP_W'(1))
  `FTES_ASSERT_IMP(a_rsp_from_resp, clk, rst, $rose(rsp_valid), $past(state) == S_RESP)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ftes_pkg::*;

  localparam int LONG_HOLD    = 600;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 188;
  localparam int TAIL_CYCLES  = 100;

  // Predict frame table responses and check them in order
  class frame_scoreboard;
    bit                used     [FRAMES];
    bit [THREAD_W-1:0] owner    [FRAMES];
    bit [PAGE_W-1:0]   upage    [FRAMES];
    bit                page_set [FRAMES];
    bit                loaded   [FRAMES];
    bit [STAMP_W-1:0]  stamp    [FRAMES];
    bit [STAMP_W-1:0]  next_stamp;
    rsp_t              expected_q[$];
    int                errors;
    int                checked;
    int                noted;
    int                cmd_seen [8];
    int                full_seen;
    int                refused_seen;
    int                evict_seen;

    function bit [STAMP_W-1:0] age_of(int i);
      return next_stamp - stamp[i];
    endfunction

    // Keep the oldest or the newest of two candidates
    function int better(int cand, int i, bit oldest);
      if (cand < 0) return i;
      if (oldest ? (age_of(i) > age_of(cand)) : (age_of(i) < age_of(cand))) return i;
      return cand;
    endfunction

    function rsp_t predict(req_t r);
      rsp_t    o;
      status_t st;
      int      cand;
      bit      slot_ok;
      bit      hit;
      o       = '0;
      st      = STAT_NONE;
      cand    = -1;
      slot_ok = used[r.slot];
      case (r.cmd)
        CMD_ALLOC: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (!used[i]) begin
              used[i]     = 1'b1;
              owner[i]    = r.thread_id;
              upage[i]    = '0;
              page_set[i] = 1'b0;
              loaded[i]   = 1'b0;
              stamp[i]    = next_stamp;
              next_stamp  = next_stamp + 1;
              cand        = i;
              break;
            end
          end
          if (cand < 0) full_seen++;
        end
        CMD_FIND: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (used[i] && owner[i] == r.thread_id) begin
              hit = r.kernel_lookup ? (r.page == PAGE_W'(i))
                                    : (page_set[i] && upage[i] == r.page);
              if (hit) cand = better(cand, i, 1'b1);
            end
          end
        end
        CMD_SET_PAGE: begin
          if (slot_ok) begin
            upage[r.slot]    = r.page;
            page_set[r.slot] = 1'b1;
            cand             = r.slot;
          end
        end
        CMD_MARK_DONE: begin
          if (slot_ok) begin
            loaded[r.slot] = 1'b1;
            cand           = r.slot;
          end
        end
        CMD_FREE: begin
          if (slot_ok) begin
            used[r.slot] = 1'b0;
            cand         = r.slot;
          end
        end
        CMD_CLEAR: begin
          if (slot_ok) begin
            if (!page_set[r.slot]) begin
              st = STAT_NO_PAGE;
              refused_seen++;
            end else begin
              o.unmap_page   = upage[r.slot];
              o.unmap_thread = owner[r.slot];
              used[r.slot]   = 1'b0;
              cand           = r.slot;
            end
          end
        end
        CMD_FREE_THREAD: begin
          for (int i = 0; i < FRAMES; i++)
            if (used[i] && owner[i] == r.thread_id) used[i] = 1'b0;
          st = STAT_OK;
        end
        default: begin
          // Oldest completed slot of the thread, else newest completed of any
          for (int i = 0; i < FRAMES; i++)
            if (used[i] && loaded[i] && owner[i] == r.thread_id)
              cand = better(cand, i, 1'b1);
          if (cand < 0)
            for (int i = 0; i < FRAMES; i++)
              if (used[i] && loaded[i]) cand = better(cand, i, 1'b0);
          if (cand >= 0) evict_seen++;
        end
      endcase
      if (cand >= 0) begin
        st           = STAT_OK;
        o.frame_slot = SLOT_W'(cand);
      end
      o.status = st;
      return o;
    endfunction

    function void note_request(req_t r);
      cmd_seen[r.cmd]++;
      noted++;
      expected_q.push_back(predict(r));
    endfunction

    task report_mismatch(string what, longint exp_val, longint got_val);
      $display("mismatch on %0s: expected %0h, got %0h (response %0d)",
               what, exp_val, got_val, checked);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected response", 0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status)
          report_mismatch("status", want.status, got.status);
        if (got.frame_slot != want.frame_slot)
          report_mismatch("frame_slot", want.frame_slot, got.frame_slot);
        if (got.unmap_page != want.unmap_page)
          report_mismatch("unmap_page", want.unmap_page, got.unmap_page);
        if (got.unmap_thread != want.unmap_thread)
          report_mismatch("unmap_thread", want.unmap_thread, got.unmap_thread);
      end
      checked++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int i = 0; i < FRAMES; i++) n += used[i];
      return n;
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  frame_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_go      = 1'b0;
  logic hold_taken   = 1'b0;
  int hold_left      = 0;

  frame_table_evict_select_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Ends a run that hangs
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Take responses, stall at random, and hold off once for a long stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  function automatic req_t mk(cmd_t c, logic [PAGE_W-1:0] pg, logic [THREAD_W-1:0] tid,
                              logic kern, logic [SLOT_W-1:0] sl);
    req_t r;
    r.cmd           = c;
    r.page          = pg;
    r.thread_id     = tid;
    r.kernel_lookup = kern;
    r.slot          = sl;
    return r;
  endfunction

  // Mostly a small pool so that finds and evictions hit
  function automatic logic [THREAD_W-1:0] random_thread();
    case ($urandom_range(0, 9))
      0, 1:    return 16'h0000;
      2, 3:    return 16'h0001;
      4, 5:    return 16'h00a5;
      6, 7:    return 16'hffff;
      default: return THREAD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [PAGE_W-1:0] random_page();
    case ($urandom_range(0, 9))
      0:       return 20'h00000;
      1:       return 20'hfffff;
      2:       return 20'h00001;
      3:       return 20'h00002;
      4:       return 20'h5a5a5;
      5:       return 20'h00003;
      default: return PAGE_W'($urandom());
    endcase
  endfunction

  // Prefer a slot in use
  function automatic logic [SLOT_W-1:0] random_slot();
    int n;
    int k;
    n = sb.used_count();
    if (n > 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < FRAMES; i++) begin
        if (sb.used[i]) begin
          if (k == 0) return SLOT_W'(i);
          k--;
        end
      end
    end
    return SLOT_W'($urandom_range(0, FRAMES - 1));
  endfunction

  function automatic req_t make_request(int w_alloc, int w_free, int w_kill);
    req_t r;
    cmd_t c;
    int   weight [8];
    int   total;
    int   pick;
    weight[CMD_ALLOC]       = w_alloc;
    weight[CMD_FIND]        = 15;
    weight[CMD_SET_PAGE]    = 15;
    weight[CMD_MARK_DONE]   = 15;
    weight[CMD_FREE]        = w_free;
    weight[CMD_CLEAR]       = 8;
    weight[CMD_FREE_THREAD] = w_kill;
    weight[CMD_EVICT]       = 12;
    total = 0;
    foreach (weight[i]) total += weight[i];
    pick = $urandom_range(0, total - 1);
    c    = CMD_ALLOC;
    while (pick >= weight[c]) begin
      pick -= weight[c];
      c = c.next();
    end
    r = mk(c, random_page(), random_thread(), 1'($urandom_range(0, 1)), random_slot());
    if (c == CMD_FIND && r.kernel_lookup && $urandom_range(0, 99) < 70)
      r.page = PAGE_W'(random_slot());
    return r;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  // Stop offering and wait for every outstanding response
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1:       begin send_idle_pct = 53; recv_stall_pct <= 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct <= 53; end
      default: begin send_idle_pct = 16; recv_stall_pct <= 16; end
    endcase
  endtask

  initial begin
    req_t directed_q[$];
    sb = new;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty table, unused slots, oldest and newest picks, clear refusal
    directed_q.push_back(mk(CMD_EVICT,       20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_FIND,        20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_FREE_THREAD, 20'h0,     16'h0000, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_SET_PAGE,    20'h12345, 16'h0001, 1'b0, 6'd5));
    directed_q.push_back(mk(CMD_CLEAR,       20'h0,     16'h0001, 1'b0, SLOT_LAST));
    directed_q.push_back(mk(CMD_ALLOC,       20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_ALLOC,       20'h0,     16'hffff, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_ALLOC,       20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_FIND,        20'h2,     16'h0001, 1'b1, 6'd0));
    directed_q.push_back(mk(CMD_FIND,        20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_CLEAR,       20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_SET_PAGE,    20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_SET_PAGE,    20'h0,     16'h0001, 1'b0, 6'd2));
    directed_q.push_back(mk(CMD_FIND,        20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_SET_PAGE,    20'hfffff, 16'hffff, 1'b0, 6'd1));
    directed_q.push_back(mk(CMD_MARK_DONE,   20'h0,     16'hffff, 1'b0, 6'd1));
    directed_q.push_back(mk(CMD_MARK_DONE,   20'h0,     16'h0001, 1'b0, 6'd2));
    directed_q.push_back(mk(CMD_MARK_DONE,   20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_EVICT,       20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_EVICT,       20'h0,     16'h1234, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_CLEAR,       20'h0,     16'h0000, 1'b0, 6'd1));
    directed_q.push_back(mk(CMD_FREE,        20'h0,     16'h0000, 1'b0, 6'd2));
    directed_q.push_back(mk(CMD_FREE,        20'h0,     16'h0000, 1'b0, 6'd2));
    directed_q.push_back(mk(CMD_FREE_THREAD, 20'h0,     16'h0001, 1'b0, 6'd0));
    directed_q.push_back(mk(CMD_MARK_DONE,   20'h0,     16'h0001, 1'b0, 6'd0));
    foreach (directed_q[i]) send_request(directed_q[i]);
    drain();

    // Hold off the response side while requests keep coming
    hold_go <= 1'b1;
    repeat (24) send_request(make_request(40, 5, 1));
    drain();

    // Alternate filling and emptying phases across the idling modes
    for (int p = 0; p < PHASES; p++) begin
      set_idling(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p % 2 == 0) send_request(make_request(60, 3, 1));
        else            send_request(make_request(10, 25, 4));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("responses never seen", 0, sb.pending());

    $display("covered %0d requests: alloc %0d, find %0d, set %0d, done %0d, free %0d, clear %0d",
             sb.noted, sb.cmd_seen[CMD_ALLOC], sb.cmd_seen[CMD_FIND],
             sb.cmd_seen[CMD_SET_PAGE], sb.cmd_seen[CMD_MARK_DONE],
             sb.cmd_seen[CMD_FREE], sb.cmd_seen[CMD_CLEAR]);
    $display("free thread %0d, evict %0d (%0d chosen), table full %0d, clears refused %0d",
             sb.cmd_seen[CMD_FREE_THREAD], sb.cmd_seen[CMD_EVICT], sb.evict_seen,
             sb.full_seen, sb.refused_seen);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== frame_table_evict_select_unit.f =====
+incdir+sv
sv/ftes_pkg.sv
sv/ftes_slot_mem.sv
sv/ftes_pick_unit.sv
sv/frame_table_evict_select_unit.sv
tb/tb_top.sv
